FILE: hw/rtl/wid_pkg.sv
// Shared types, codes and widths for the work item dispenser.
package wid_pkg;

  localparam int LINE_W     = 16;
  localparam int CNT_W      = LINE_W + 1;
  localparam int MODE_W     = 2;
  localparam int WC_W       = 5;
  localparam int WORKER_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LINE_W;

  localparam logic [MODE_W-1:0] MODE_BLOCK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CYCLIC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DYNAMIC = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd3;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LINES  = 2'd2;

  typedef struct packed {
    logic                cmd;
    logic [WORKER_W-1:0] worker;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [LINE_W-1:0] line_number;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIVIDE,
    ST_SWEEP,
    ST_RESPOND
  } state_t;

  typedef struct packed {
    logic load_item;
    logic div_start;
    logic sweep_init;
    logic sweep_step;
    logic mem_read;
    logic respond;
  } ctrl_t;

  typedef struct packed {
    logic item_restart;
    logic div_done;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/wid_div.sv
// Restoring divider, one quotient bit per cycle.
module wid_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [STEP_W-1:0] steps;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign quot  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        quo   <= num;
        steps <= STEP_W'(NUM_W);
      end else if (steps != '0) begin
        rem   <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        quo   <= {quo[NUM_W-2:0], fits};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/wid_ctrl.sv
// Controller state machine: sequences restart and request items.
module wid_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  wid_pkg::status_t st,
  output wid_pkg::ctrl_t   ctl
);
  import wid_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_stall  = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          ctl.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (st.item_restart) begin
          ctl.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end else begin
          ctl.mem_read = 1'b1;
          state_next   = ST_RESPOND;
        end
      end
      ST_DIVIDE: begin
        if (st.div_done) begin
          ctl.sweep_init = 1'b1;
          state_next     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        ctl.sweep_step = 1'b1;
        if (st.sweep_last) begin
          state_next = ST_RESPOND;
        end
      end
      ST_RESPOND: begin
        // hold until the output register can take the item
        if (st.out_free) begin
          ctl.respond = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/wid_datapath.sv
// Datapath: registers, per-worker counter memory, divider and output register.
module wid_datapath #(
  parameter int MAX_WORKERS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wid_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wid_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wid_pkg::req_t                       req,
  input  wid_pkg::ctrl_t                      ctl,
  output wid_pkg::status_t                    st,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output wid_pkg::rsp_t                       rsp
);
  import wid_pkg::*;

  localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CW = $clog2(MAX_WORKERS + 1);
  localparam int KW = (CW > WC_W) ? CW : WC_W;
  localparam int PW = LINE_W + KW;

  // configuration
  logic [MODE_W-1:0] mode;
  logic [WC_W-1:0]   worker_count;
  logic [LINE_W-1:0] total_lines;

  // state
  req_t              item;
  logic [CNT_W-1:0]  next_line [MAX_WORKERS];
  logic [CNT_W-1:0]  rd_data;
  logic [MAX_WORKERS-1:0] started;
  logic [CNT_W-1:0]  shared_counter;
  logic [LINE_W-1:0] block_size;
  logic [IW-1:0]     sweep_idx;
  logic [CNT_W-1:0]  sweep_acc;
  logic [PW-1:0]     block_end;

  // derived
  logic [KW-1:0]     wc_ext;
  logic [KW-1:0]     eff;
  logic [KW-1:0]     wk_ext;
  logic [IW-1:0]     idx;
  logic [KW-1:0]     sw_ext;
  logic              sw_in;
  logic [CNT_W-1:0]  total_ext;
  logic [CNT_W-1:0]  eff_cnt;
  logic [CNT_W-1:0]  sweep_val;
  logic [CNT_W-1:0]  div_num;
  logic              div_done;
  logic [CNT_W-1:0]  div_quot;
  logic              wk_ok;
  logic              n_ok;
  logic              dyn_ok;
  logic [CNT_W-1:0]  dyn_line;
  logic [CNT_W:0]    cyc_sum;
  logic [CNT_W-1:0]  n_next;
  logic              grant;
  logic [LINE_W-1:0] line;
  logic              mem_we;
  logic [IW-1:0]     mem_addr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              out_free;

  assign wc_ext    = KW'(worker_count);
  assign eff       = (worker_count == '0) ? KW'(1) :
                     ((wc_ext > KW'(MAX_WORKERS)) ? KW'(MAX_WORKERS) : wc_ext);
  assign wk_ext    = KW'(item.worker);
  assign idx       = wk_ext[IW-1:0];
  assign sw_ext    = KW'(sweep_idx);
  assign sw_in     = sw_ext < eff;
  assign total_ext = CNT_W'(total_lines);
  assign eff_cnt   = CNT_W'(eff);
  assign div_num   = total_ext + eff_cnt - CNT_W'(1);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign st.item_restart = item.cmd == CMD_RESTART;
  assign st.div_done     = div_done;
  assign st.sweep_last   = sweep_idx == IW'(MAX_WORKERS - 1);
  assign st.out_free     = out_free;

  wid_div #(
    .NUM_W (CNT_W),
    .DEN_W (KW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (div_num),
    .den   (eff),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BLOCK;
      worker_count <= WC_W'(1);
      total_lines  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:         mode         <= cfg_data[MODE_W-1:0];
        REG_WORKER_COUNT: worker_count <= cfg_data[WC_W-1:0];
        REG_TOTAL_LINES:  total_lines  <= cfg_data[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // initial counter value of the worker under the sweep
  always_comb begin
    sweep_val = '0;
    if (sw_in) begin
      case (mode)
        MODE_BLOCK:   sweep_val = sweep_acc;
        MODE_CYCLIC:  sweep_val = CNT_W'(sw_ext) + CNT_W'(1);
        MODE_REVERSE: sweep_val = (total_ext > CNT_W'(sw_ext)) ?
                                  total_ext - CNT_W'(sw_ext) : '0;
        default:      sweep_val = '0;
      endcase
    end
  end

  // request evaluation
  assign wk_ok    = (wk_ext < eff) && started[idx];
  assign dyn_ok   = shared_counter < total_ext;
  assign dyn_line = shared_counter + CNT_W'(1);
  assign cyc_sum  = (CNT_W + 1)'(rd_data) + (CNT_W + 1)'(eff_cnt);

  always_comb begin
    n_ok = (rd_data != '0) && (rd_data <= total_ext);
    if (mode == MODE_BLOCK && PW'(rd_data) > block_end) begin
      n_ok = 1'b0;
    end
    case (mode)
      MODE_BLOCK:   n_next = rd_data + CNT_W'(1);
      MODE_CYCLIC:  n_next = cyc_sum[CNT_W] ? '1 : cyc_sum[CNT_W-1:0];
      MODE_REVERSE: n_next = (rd_data > eff_cnt) ? rd_data - eff_cnt : '0;
      default:      n_next = rd_data;
    endcase
    if (item.cmd == CMD_RESTART || !wk_ok) begin
      grant = 1'b0;
    end else if (mode == MODE_DYNAMIC) begin
      grant = dyn_ok;
    end else begin
      grant = n_ok;
    end
    line = (mode == MODE_DYNAMIC) ? dyn_line[LINE_W-1:0] : rd_data[LINE_W-1:0];
  end

  assign mem_we    = ctl.sweep_step || (ctl.respond && grant && mode != MODE_DYNAMIC);
  assign mem_addr  = ctl.sweep_step ? sweep_idx : idx;
  assign mem_wdata = ctl.sweep_step ? sweep_val : n_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_line[mem_addr] <= mem_wdata;
    end
    if (ctl.mem_read) begin
      rd_data <= next_line[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item <= req;
    end
    if (ctl.mem_read) begin
      block_end <= PW'(block_size) * (PW'(wk_ext) + PW'(1));
    end
    if (ctl.sweep_init) begin
      sweep_idx <= '0;
      sweep_acc <= CNT_W'(1);
    end else if (ctl.sweep_step) begin
      sweep_idx <= sweep_idx + IW'(1);
      sweep_acc <= sweep_acc + CNT_W'(block_size);
    end
    if (ctl.respond) begin
      rsp.granted     <= grant;
      rsp.line_number <= grant ? line : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= '0;
      shared_counter <= '0;
      block_size     <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (ctl.sweep_init) begin
        shared_counter <= '0;
        block_size     <= div_quot[LINE_W-1:0];
      end else if (ctl.respond && grant && mode == MODE_DYNAMIC) begin
        shared_counter <= dyn_line;
      end
      if (ctl.sweep_step) begin
        started[sweep_idx] <= sw_in;
      end
      if (ctl.respond) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/work_item_dispenser_core.sv
// Line dispenser for up to MAX_WORKERS workers. A request item passes through the steps
// accept, counter memory read and respond, and yields one result; a restart item
// runs a bit-serial divide for the block size, then a sweep that rewrites the
// counter of each of the MAX_WORKERS slots in the single write port memory, then
// the respond step. The result sits in an output register, so the next item can
// be accepted while it waits to be taken.
module work_item_dispenser_core #(
  parameter int MAX_WORKERS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  wid_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output wid_pkg::rsp_t                  rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wid_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wid_pkg::*;

  ctrl_t   ctl;
  status_t st;

  assign cfg_ready = 1'b1;

  wid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .ctl       (ctl)
  );

  wid_datapath #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .ctl       (ctl),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item accepted while another is in flight");

  a_respond_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctl.respond |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_sweep_after_divide: assert property (@(posedge clk) disable iff (rst)
    ctl.sweep_init |-> st.div_done)
    else $error("counter sweep started before block size was ready");

endmodule
